/* design/cvpf_pkg.sv */
package cvpf_pkg;

  // Width of the high time and run counters.
  localparam int COUNT_WIDTH = 16;
  // Width used when a counter is compared with a 16 bit register.
  localparam int CMP_WIDTH   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam int IN_DATA_WIDTH   = 8;
  localparam int OUT_DATA_WIDTH  = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LONG_HIGH   = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RUN_TIMEOUT = 8'd1;

  localparam logic [15:0] LONG_HIGH_RESET   = 16'd625;
  localparam logic [15:0] RUN_TIMEOUT_RESET = 16'd7500;

  // Item kinds carried on in_tuser.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_OPEN = 1'b1;

  // Outlet selection codes.
  localparam logic OUTLET_UPPER = 1'b0;
  localparam logic OUTLET_LOWER = 1'b1;

  // Outlet status codes.
  localparam logic [1:0] STATUS_UNKNOWN = 2'd0;
  localparam logic [1:0] STATUS_UPPER   = 2'd1;
  localparam logic [1:0] STATUS_LOWER   = 2'd2;

  // Cam position codes.
  localparam logic [1:0] POS_UNKNOWN = 2'd0;
  localparam logic [1:0] POS_UP      = 2'd1;
  localparam logic [1:0] POS_FULL    = 2'd2;
  localparam logic [1:0] POS_DOWN    = 2'd3;

  typedef struct packed {
    logic op;
    logic outlet_select;
    logic pump_on;
    logic paused;
    logic cam_switch;
    logic test_mode;
    logic workshop_mode;
  } item_t;

  typedef struct packed {
    logic [15:0] last_high_ticks;
    logic        timeout_error;
    logic        motor_pin;
    logic        motor_drive;
    logic [1:0]  cam_position;
    logic        done_res;
    logic [1:0]  outlet_state;
  } result_t;

  // Handshake between the input register and the rest of the block.
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

/* design/cvpf_in_reg.sv */
module cvpf_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_op,
  input  logic [5:0]           in_fields,
  input  logic                 advance,
  output logic                 valid,
  output cvpf_pkg::item_t      item
);

  logic            valid_r;
  logic            valid_nxt;
  cvpf_pkg::item_t item_r;

  assign in_tready = !valid_r || advance;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.op            <= in_op;
      item_r.outlet_select <= in_fields[0];
      item_r.pump_on       <= in_fields[1];
      item_r.paused        <= in_fields[2];
      item_r.cam_switch    <= in_fields[3];
      item_r.test_mode     <= in_fields[4];
      item_r.workshop_mode <= in_fields[5];
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

/* design/cvpf_core.sv */
module cvpf_core (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [cvpf_pkg::CFG_INDEX_WIDTH-1:0]     cfg_idx,
  input  logic [cvpf_pkg::CFG_DATA_WIDTH-1:0]      cfg_wdata,
  input  cvpf_pkg::stage_ctl_t                     ctl,
  input  cvpf_pkg::item_t                          item,
  output cvpf_pkg::result_t                        result
);

  localparam int CW = cvpf_pkg::COUNT_WIDTH;
  localparam int MW = cvpf_pkg::CMP_WIDTH;
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  logic [15:0]   long_high_r;
  logic [15:0]   run_timeout_r;

  logic          done_r,       done_nxt;
  logic [1:0]    status_r,     status_nxt;
  logic          target_r,     target_nxt;
  logic [1:0]    pos_r,        pos_nxt;
  logic          low_seen_r,   low_seen_nxt;
  logic          await_fall_r, await_fall_nxt;
  logic [CW-1:0] high_cnt_r,   high_cnt_nxt;
  logic [CW-1:0] meas_high_r,  meas_high_nxt;
  logic [CW-1:0] run_cnt_r,    run_cnt_nxt;
  logic          pin_r,        pin_nxt;
  logic          drive;
  logic          timeout;
  logic          already;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_high_r   <= cvpf_pkg::LONG_HIGH_RESET;
      run_timeout_r <= cvpf_pkg::RUN_TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        cvpf_pkg::CFG_LONG_HIGH:   long_high_r   <= cfg_wdata;
        cvpf_pkg::CFG_RUN_TIMEOUT: run_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    done_nxt       = done_r;
    status_nxt     = status_r;
    target_nxt     = target_r;
    pos_nxt        = pos_r;
    low_seen_nxt   = low_seen_r;
    await_fall_nxt = await_fall_r;
    high_cnt_nxt   = high_cnt_r;
    meas_high_nxt  = meas_high_r;
    run_cnt_nxt    = run_cnt_r;
    pin_nxt        = pin_r;
    drive          = 1'b0;
    timeout        = 1'b0;
    already        = 1'b0;

    if (item.op == cvpf_pkg::OP_OPEN) begin
      already = (item.outlet_select == cvpf_pkg::OUTLET_UPPER &&
                 status_r == cvpf_pkg::STATUS_UPPER) ||
                (item.outlet_select == cvpf_pkg::OUTLET_LOWER &&
                 status_r == cvpf_pkg::STATUS_LOWER);
      if (!already) begin
        done_nxt     = 1'b0;
        status_nxt   = cvpf_pkg::STATUS_UNKNOWN;
        low_seen_nxt = 1'b0;
        target_nxt   = item.outlet_select;
        if (item.outlet_select == cvpf_pkg::OUTLET_UPPER) begin
          pos_nxt = cvpf_pkg::POS_UNKNOWN;
        end
      end
    end else begin
      drive = item.pump_on && !done_r && !item.paused;
      if (drive) begin
        if (!item.cam_switch) begin
          low_seen_nxt = 1'b1;
        end
        if (item.cam_switch && low_seen_r) begin
          await_fall_nxt = 1'b1;
          high_cnt_nxt   = (high_cnt_r == COUNT_MAX) ? COUNT_MAX : high_cnt_r + 1'b1;
        end
        // Falling edge of the cam switch closes a high-time measurement.
        if (await_fall_nxt && !item.cam_switch) begin
          meas_high_nxt  = high_cnt_nxt;
          await_fall_nxt = 1'b0;
          high_cnt_nxt   = '0;
          if (pos_r == cvpf_pkg::POS_FULL) begin
            pos_nxt = cvpf_pkg::POS_DOWN;
          end else if (pos_r == cvpf_pkg::POS_UP) begin
            pos_nxt = cvpf_pkg::POS_FULL;
          end
          if (MW'(meas_high_nxt) >= MW'(long_high_r)) begin
            pos_nxt = cvpf_pkg::POS_UP;
          end
        end
        if ((pos_nxt == cvpf_pkg::POS_UP && target_r == cvpf_pkg::OUTLET_UPPER) ||
            (pos_nxt == cvpf_pkg::POS_DOWN && target_r == cvpf_pkg::OUTLET_LOWER)) begin
          done_nxt      = 1'b1;
          status_nxt    = (target_r == cvpf_pkg::OUTLET_UPPER) ?
                          cvpf_pkg::STATUS_UPPER : cvpf_pkg::STATUS_LOWER;
          high_cnt_nxt  = '0;
          meas_high_nxt = '0;
        end
      end
      if (!item.workshop_mode) begin
        pin_nxt = drive;
      end
      if (drive) begin
        if (item.test_mode) begin
          run_cnt_nxt = (run_cnt_r == COUNT_MAX) ? COUNT_MAX : run_cnt_r + 1'b1;
          timeout     = MW'(run_cnt_nxt) > MW'(run_timeout_r);
        end
      end else begin
        run_cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r       <= 1'b1;
      status_r     <= cvpf_pkg::STATUS_UNKNOWN;
      target_r     <= cvpf_pkg::OUTLET_UPPER;
      pos_r        <= cvpf_pkg::POS_UNKNOWN;
      low_seen_r   <= 1'b0;
      await_fall_r <= 1'b0;
      high_cnt_r   <= '0;
      meas_high_r  <= '0;
      run_cnt_r    <= '0;
      pin_r        <= 1'b0;
    end else if (ctl.valid && ctl.advance) begin
      done_r       <= done_nxt;
      status_r     <= status_nxt;
      target_r     <= target_nxt;
      pos_r        <= pos_nxt;
      low_seen_r   <= low_seen_nxt;
      await_fall_r <= await_fall_nxt;
      high_cnt_r   <= high_cnt_nxt;
      meas_high_r  <= meas_high_nxt;
      run_cnt_r    <= run_cnt_nxt;
      pin_r        <= pin_nxt;
    end
  end

  always_comb begin
    result.outlet_state    = status_nxt;
    result.done_res        = done_nxt;
    result.cam_position    = pos_nxt;
    result.motor_drive     = drive;
    result.motor_pin       = pin_nxt;
    result.timeout_error   = timeout;
    result.last_high_ticks = 16'(MW'(meas_high_nxt));
  end

endmodule

/* design/cvpf_out_reg.sv */
module cvpf_out_reg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  cvpf_pkg::result_t                 result,
  output logic                              advance,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cvpf_pkg::OUT_DATA_WIDTH-1:0] out_tdata
);

  logic              valid_r;
  logic              valid_nxt;
  cvpf_pkg::result_t result_r;

  // The output register takes a new result when it is empty or being drained.
  assign advance   = !valid_r || out_tready;
  assign valid_nxt = advance ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      result_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = result_r;

endmodule

/* design/cam_valve_position_finder.sv */
// Each input item is registered in the input register, and its result in the output register.
// Throughput: one item per cycle unless out_tready stalls; the state update is one combinational
// pass between input and output registers, so back-to-back items carry state without a bubble.
// Reset: synchronous, active-low rst_n empties both registers, restores the registers of the
// configuration port to their defaults and returns the valve state to done with an unknown cam.
module cam_valve_position_finder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input channel.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // tdata from bit 0: outlet_select, pump_on, paused, cam_switch, test_mode,
  // workshop_mode, two zero bits.
  input  logic [cvpf_pkg::IN_DATA_WIDTH-1:0]    in_tdata,
  // tuser: op (0 = tick, 1 = open request).
  input  logic                                  in_tuser,
  // Result channel.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // tdata from bit 0: outlet_state[1:0], done_res, cam_position[1:0], motor_drive,
  // motor_pin, timeout_error, last_high_ticks[15:0].
  output logic [cvpf_pkg::OUT_DATA_WIDTH-1:0]   out_tdata,
  // Configuration write channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cvpf_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [cvpf_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

  cvpf_pkg::stage_ctl_t ctl;
  cvpf_pkg::item_t      item;
  cvpf_pkg::result_t    result;
  logic                 advance;
  logic                 in_valid;

  // Configuration writes are always taken; the user must issue them only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  // The input register holds the item being worked on; it moves on when the
  // output register can take its result.
  cvpf_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .in_fields (in_tdata[5:0]),
    .advance   (advance),
    .valid     (in_valid),
    .item      (item)
  );

  assign ctl.valid   = in_valid;
  assign ctl.advance = advance;

  // The core keeps the valve state and commits it only when the item's result
  // is written into the output register, so a stalled item is never counted twice.
  cvpf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .ctl       (ctl),
    .item      (item),
    .result    (result)
  );

  cvpf_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .result     (result),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* design/cvpf_checker.sv */
module cvpf_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tready,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [cvpf_pkg::OUT_DATA_WIDTH-1:0]   out_tdata
);

  // No result is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A timeout is only reported on a tick that drove the motor.
  a_timeout_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7] |-> out_tdata[5])
    else $error("timeout without motor drive");

  // An open outlet is only reported once the action is done.
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != cvpf_pkg::STATUS_UNKNOWN) |-> out_tdata[2])
    else $error("outlet open while action not done");

  // With the result register empty, the block always takes a new input item.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input refused while the result register is empty");

endmodule

bind cam_valve_position_finder cvpf_checker u_cvpf_checker (.*);
